// ===== sv/xmbf_pkg.sv =====
// Shared constants for the XOR mask basis filter.
// No dependencies; compile this file first.
package xmbf_pkg;

    // Fixed width of the candidate mask port.
    localparam int CAND_W  = 64;

    // Fixed width of the kept-count result field.
    localparam int COUNT_W = 7;

endpackage

// ===== sv/xmbf_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module xmbf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/xor_mask_basis_filter.sv =====
// An item is first reduced against the stored rows from the top bit down; if accepted, the
// new row (pivot p) is folded into the rows above it, and the result is then posted.
// A new mask is taken only once the result of the last one is posted; the single read
// and single write port of the row RAM let the walk cover one row per cycle. Reset
// clears the pivot valid bits, the kept count and the handshake state at once; the row
// RAM is not cleared, as a row's data is used only while its pivot is valid.
//
// Depends on xmbf_pkg and xmbf_ram.
module xor_mask_basis_filter #(
    parameter int MASK_BITS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cand_valid,
    output logic                        cand_stall,
    input  logic [xmbf_pkg::CAND_W-1:0] candidate_mask,
    input  logic                        starts_set,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic                        accepted,
    output logic [xmbf_pkg::COUNT_W-1:0] kept_count
);

    import xmbf_pkg::*;

    // Index width for a row, and width of the kept count (0..MASK_BITS).
    localparam int IW = $clog2(MASK_BITS);
    localparam int CW = $clog2(MASK_BITS + 1);
    localparam logic [IW-1:0] TOP_IDX = IW'(MASK_BITS - 1);

    // The block walks one row per cycle. REDUCE scans the pivots from the top bit
    // down and XORs in each matching row. UPDATE sweeps the rows above the new
    // pivot, clears the pivot bit out of them, and finally writes the new row.
    // FINISH hands the result to the output register.
    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_UPDATE,
        S_FINISH
    } state_t;

    state_t                state_reg;
    logic [MASK_BITS-1:0]  x_reg;
    logic [IW-1:0]         idx_reg;
    logic [IW-1:0]         piv_reg;
    logic                  found_reg;
    logic                  acc_reg;
    logic [MASK_BITS-1:0]  valid_reg;
    logic [CW-1:0]         size_reg;
    logic                  out_valid_reg;
    logic                  out_acc_reg;
    logic [COUNT_W-1:0]    out_count_reg;

    // RAM ports.
    logic                  ram_wr_en;
    logic [IW-1:0]         ram_wr_addr;
    logic [MASK_BITS-1:0]  ram_wr_data;
    logic                  ram_rd_en;
    logic [IW-1:0]         ram_rd_addr;
    logic [MASK_BITS-1:0]  ram_rd_data;

    logic                  take_cand;
    logic                  out_free;
    logic                  reduce_hit;
    logic                  fold_hit;
    logic [MASK_BITS-1:0]  x_next;
    logic [IW-1:0]         idx_dec;

    assign take_cand = (state_reg == S_IDLE) && cand_valid;
    assign out_free  = !out_valid_reg || !result_stall;
    assign idx_dec   = idx_reg - 1'b1;

    // While reducing, the row read last cycle belongs to pivot idx_reg. Rows above
    // it are already applied, so bit idx_reg of x_reg holds its settled value.
    assign reduce_hit = x_reg[idx_reg] && valid_reg[idx_reg];
    assign x_next     = reduce_hit ? (x_reg ^ ram_rd_data) : x_reg;

    // While updating, a valid row that has the new pivot bit set gets the remainder.
    assign fold_hit = valid_reg[idx_reg] && ram_rd_data[piv_reg];

    // Read address: one row ahead of the row being worked on. A new walk always
    // starts at the top row.
    always_comb
    begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = TOP_IDX;
        case (state_reg)
            S_IDLE:
            begin
                ram_rd_en   = take_cand;
                ram_rd_addr = TOP_IDX;
            end
            S_REDUCE:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = (idx_reg == '0) ? TOP_IDX : idx_dec;
            end
            S_UPDATE:
            begin
                ram_rd_en   = (idx_reg != piv_reg);
                ram_rd_addr = idx_dec;
            end
            default:
            begin
                ram_rd_en   = 1'b0;
                ram_rd_addr = TOP_IDX;
            end
        endcase
    end

    // Write port: the row under the sweep is written back only when it changes,
    // and the new row lands at its pivot on the last update cycle.
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg;
        ram_wr_data = x_reg;
        if (state_reg == S_UPDATE)
        begin
            if (idx_reg == piv_reg)
            begin
                ram_wr_en   = 1'b1;
                ram_wr_data = x_reg;
            end
            else
            begin
                ram_wr_en   = fold_hit;
                ram_wr_data = ram_rd_data ^ x_reg;
            end
        end
    end

    xmbf_ram #(
        .WIDTH (MASK_BITS),
        .DEPTH (MASK_BITS)
    ) u_rows (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            size_reg      <= '0;
            found_reg     <= 1'b0;
            acc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            piv_reg       <= '0;
            x_reg         <= '0;
            out_acc_reg   <= 1'b0;
            out_count_reg <= '0;
        end
        else
        begin
            // The output register is refilled from FINISH, and otherwise drains on
            // its own once the beat is taken.
            if ((state_reg == S_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (take_cand)
                    begin
                        x_reg     <= candidate_mask[MASK_BITS-1:0];
                        idx_reg   <= TOP_IDX;
                        found_reg <= 1'b0;
                        if (starts_set)
                        begin
                            valid_reg <= '0;
                            size_reg  <= '0;
                        end
                        state_reg <= S_REDUCE;
                    end
                end

                S_REDUCE:
                begin
                    x_reg <= x_next;
                    // The highest bit that survives with no row of its own is the
                    // pivot of the remainder.
                    if (!found_reg && x_reg[idx_reg] && !valid_reg[idx_reg])
                    begin
                        found_reg <= 1'b1;
                        piv_reg   <= idx_reg;
                    end
                    if (idx_reg == '0)
                    begin
                        idx_reg <= TOP_IDX;
                        if (found_reg || (x_reg[0] && !valid_reg[0]))
                        begin
                            state_reg <= S_UPDATE;
                        end
                        else
                        begin
                            acc_reg   <= 1'b0;
                            state_reg <= S_FINISH;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_dec;
                    end
                end

                S_UPDATE:
                begin
                    if (idx_reg == piv_reg)
                    begin
                        valid_reg[piv_reg] <= 1'b1;
                        size_reg           <= size_reg + 1'b1;
                        acc_reg            <= 1'b1;
                        state_reg          <= S_FINISH;
                    end
                    else
                    begin
                        idx_reg <= idx_dec;
                    end
                end

                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_acc_reg   <= acc_reg;
                        out_count_reg <= COUNT_W'(size_reg);
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cand_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign accepted     = out_acc_reg;
    assign kept_count   = out_count_reg;

    // The kept count always matches the number of pivots in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(size_reg))
        else $error("kept count differs from number of valid pivots");

    // The count never passes the mask width.
    assert property (@(posedge clk) disable iff (!rst_n)
        int'(size_reg) <= MASK_BITS)
        else $error("kept count exceeds mask width");

    // A new row is only ever written at a pivot that had no row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE) && (idx_reg == piv_reg) |-> !valid_reg[piv_reg])
        else $error("new row written over an existing pivot");

    // The row being inserted keeps its pivot bit set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE) |-> x_reg[piv_reg])
        else $error("remainder lost its pivot bit");

endmodule
